/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int NODE_BITS_DEF = 16;
    localparam int COST_BITS_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int NODE_W   = 16;
    localparam int COST_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_POP    = 3'd1,
        MODE_CHANGE = 3'd2,
        MODE_SETPAR = 3'd3,
        MODE_LOOKUP = 3'd4,
        MODE_READ   = 3'd5
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* design/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Cost-ordered queue of (node, cost, parent) entries held in one memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// request  in         in_valid/in_ready   mode node_id cost_in parent_in slot_index
// result   out        out_valid/out_ready status found entry_* head_* entry_count
//
// One read port and one write port. Insert and pop stream the memory one entry
// per cycle. Lookup and set parent read and check one entry at a time, taking
// the next entry only once the last one is checked; read index fetches one
// slot. Change cost runs a stable insertion sort over the whole queue.
// Reset clears the count; entries are undefined until written.
// A stalled result holds the block; the next request is taken once it leaves.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY  = spq_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spq_pkg::MODE_W-1:0]   mode,
    input  logic [spq_pkg::NODE_W-1:0]   node_id,
    input  logic [spq_pkg::COST_W-1:0]   cost_in,
    input  logic [spq_pkg::NODE_W-1:0]   parent_in,
    input  logic [spq_pkg::SLOT_W-1:0]   slot_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [spq_pkg::STATUS_W-1:0] status,
    output logic                         found,
    output logic [spq_pkg::NODE_W-1:0]   entry_node,
    output logic [spq_pkg::COST_W-1:0]   entry_cost,
    output logic [spq_pkg::NODE_W-1:0]   entry_parent,
    output logic [spq_pkg::NODE_W-1:0]   head_node,
    output logic [spq_pkg::COST_W-1:0]   head_cost,
    output logic [spq_pkg::NODE_W-1:0]   head_parent,
    output logic [6:0]                   entry_count
);

    localparam int NODE_BITS = spq_pkg::NODE_W;
    localparam int COST_BITS = spq_pkg::COST_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [COST_BITS-1:0] cost;
        logic [NODE_BITS-1:0] parent;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SCAN, S_SHIFT, S_PUT, S_SORT_RD, S_SORT_MV,
        S_HEAD, S_HEAD_WAIT, S_FIND, S_FIND_WAIT, S_DONE
    } state_t;

    entry_t mem [CAPACITY];
    entry_t rdata_reg;

    state_t               state_reg;
    logic [CW-1:0]        occ_reg;
    logic [spq_pkg::MODE_W-1:0] mode_reg;
    logic [NODE_BITS-1:0] node_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [NODE_BITS-1:0] par_reg;
    logic [spq_pkg::SLOT_W-1:0] slot_reg;
    logic [CW-1:0]        idx_reg;     // walking index
    logic [CW-1:0]        outer_reg;   // sort outer index
    entry_t               hold_reg;    // entry being carried
    logic                 rd_pend_reg;
    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic                 found_reg;
    entry_t               ent_reg;
    entry_t               head_reg;
    logic                 out_valid_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        wr_data;
    entry_t        rd_cost_upd;
    entry_t        rd_par_upd;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    function automatic logic [AW-1:0] ad(input logic [CW-1:0] v);
        return v[AW-1:0];
    endfunction

    // Read data with the request's cost or parent applied on a node match.
    assign rd_cost_upd = (rdata_reg.node == node_reg)
                         ? entry_t'{rdata_reg.node, cost_reg, rdata_reg.parent}
                         : rdata_reg;
    assign rd_par_upd  = (rdata_reg.node == node_reg)
                         ? entry_t'{rdata_reg.node, rdata_reg.cost, par_reg}
                         : rdata_reg;

    // Memory control, combinational from state.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = hold_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = ad(idx_reg);
            end
            S_SHIFT:
            begin
                rd_en = 1'b1;
                if (mode_reg == spq_pkg::MODE_POP)
                    rd_addr = ad(idx_reg);
                else if (rd_pend_reg)
                    rd_addr = ad(idx_reg - CW'(2));   // one entry ahead of the write
                else
                    rd_addr = ad(idx_reg - CW'(1));
            end
            S_SORT_RD, S_SORT_MV, S_FIND:
            begin
                rd_en   = 1'b1;
                rd_addr = ad(idx_reg);
            end
            S_HEAD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            default: ;
        endcase
        unique case (state_reg)
            S_SHIFT:
            begin
                if (rd_pend_reg)
                begin
                    if (mode_reg == spq_pkg::MODE_POP)
                    begin
                        if (idx_reg > CW'(1))
                        begin
                            wr_en   = 1'b1;
                            wr_addr = ad(idx_reg - CW'(2));
                            wr_data = rdata_reg;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ad(idx_reg);
                        wr_data = rdata_reg;
                    end
                end
            end
            S_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = ad(idx_reg);
                wr_data = hold_reg;
            end
            S_SORT_MV:
            begin
                if (rd_pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ad(idx_reg + CW'(1));
                    wr_data = (mode_reg == spq_pkg::MODE_CHANGE) ? rd_cost_upd : rdata_reg;
                end
            end
            S_FIND_WAIT:
            begin
                if (mode_reg == spq_pkg::MODE_SETPAR && rdata_reg.node == node_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ad(idx_reg);
                    wr_data = rd_par_upd;
                end
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    // Pop uses the same shifter downward: idx walks up, writing idx-2 <= idx-1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= spq_pkg::ST_OK;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg   <= mode;
                        node_reg   <= node_id;
                        cost_reg   <= cost_in;
                        par_reg    <= parent_in;
                        slot_reg   <= slot_index;
                        status_reg <= spq_pkg::ST_OK;
                        found_reg  <= 1'b0;
                        ent_reg    <= '0;
                        idx_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg  <= S_RD;
                    end
                end
                S_RD:
                begin
                    priority case (mode_reg)
                        spq_pkg::MODE_INSERT:
                        begin
                            hold_reg <= '{node_reg, cost_reg, par_reg};
                            if (occ_reg == CW'(CAPACITY))
                            begin
                                status_reg <= spq_pkg::ST_FULL;
                                state_reg  <= S_HEAD;
                            end
                            else if (occ_reg == '0)
                                state_reg <= S_PUT;
                            else
                                state_reg <= S_SCAN;
                        end
                        spq_pkg::MODE_POP:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_reg <= spq_pkg::ST_EMPTY;
                                state_reg  <= S_HEAD;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_SHIFT;
                            end
                        end
                        spq_pkg::MODE_CHANGE:
                        begin
                            // outer pass k: pull entry k, shift larger ones up
                            outer_reg <= '0;
                            idx_reg   <= '0;
                            state_reg <= (occ_reg == '0) ? S_FIND : S_SORT_RD;
                        end
                        spq_pkg::MODE_SETPAR, spq_pkg::MODE_LOOKUP:
                            state_reg <= S_FIND;
                        spq_pkg::MODE_READ:
                        begin
                            if (32'(slot_reg) < 32'(occ_reg))
                            begin
                                idx_reg   <= CW'(slot_reg);
                                state_reg <= S_FIND;
                            end
                            else
                                state_reg <= S_HEAD;
                        end
                        default: state_reg <= S_HEAD;
                    endcase
                end
                S_SCAN:
                begin
                    // rdata from previous scan address
                    if (rd_pend_reg && cost_reg < rdata_reg.cost)
                    begin
                        // insert at idx-1: shift from top down
                        idx_reg     <= occ_reg;
                        outer_reg   <= idx_reg - CW'(1);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SHIFT;
                    end
                    else if (idx_reg == occ_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_PUT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        idx_reg     <= idx_reg + CW'(1);
                    end
                end
                S_SHIFT:
                begin
                    if (mode_reg == spq_pkg::MODE_POP)
                    begin
                        if (rd_pend_reg)
                        begin
                            // rdata holds entry idx-1; entry 0 leaves the queue
                            if (idx_reg == CW'(1))
                                ent_reg <= rdata_reg;
                            if (idx_reg == occ_reg)
                            begin
                                rd_pend_reg <= 1'b0;
                                occ_reg     <= occ_reg - CW'(1);
                                found_reg   <= 1'b1;
                                state_reg   <= S_HEAD;
                            end
                            else
                                idx_reg <= idx_reg + CW'(1);
                        end
                        else
                        begin
                            rd_pend_reg <= 1'b1;
                            idx_reg     <= idx_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (rd_pend_reg)
                        begin
                            if (idx_reg - CW'(1) == outer_reg)
                            begin
                                idx_reg     <= outer_reg;
                                rd_pend_reg <= 1'b0;
                                state_reg   <= S_PUT;
                            end
                            else
                                idx_reg <= idx_reg - CW'(1);
                        end
                        else
                            rd_pend_reg <= 1'b1;
                    end
                end
                S_PUT:
                begin
                    if (mode_reg == spq_pkg::MODE_INSERT)
                    begin
                        occ_reg   <= occ_reg + CW'(1);
                        state_reg <= S_HEAD;
                    end
                    else
                    begin
                        // next sort pass
                        if (outer_reg + CW'(1) == occ_reg)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_FIND;
                        end
                        else
                        begin
                            outer_reg <= outer_reg + CW'(1);
                            idx_reg   <= outer_reg + CW'(1);
                            state_reg <= S_SORT_RD;
                        end
                    end
                end
                S_SORT_RD:
                begin
                    // fetch entry outer, then walk down
                    if (rd_pend_reg)
                    begin
                        hold_reg    <= rd_cost_upd;
                        rd_pend_reg <= 1'b0;
                        if (outer_reg == '0)
                            state_reg <= S_PUT;
                        else
                        begin
                            idx_reg   <= outer_reg - CW'(1);
                            state_reg <= S_SORT_MV;
                        end
                    end
                    else
                        rd_pend_reg <= 1'b1;
                end
                S_SORT_MV:
                begin
                    // entries below outer are already updated and sorted
                    if (rd_pend_reg)
                    begin
                        if (rdata_reg.cost > hold_reg.cost)
                        begin
                            // moved up by write; continue down
                            if (idx_reg == '0)
                            begin
                                rd_pend_reg <= 1'b0;
                                state_reg   <= S_PUT;
                            end
                            else
                            begin
                                idx_reg     <= idx_reg - CW'(1);
                                rd_pend_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            idx_reg     <= idx_reg + CW'(1);
                            rd_pend_reg <= 1'b0;
                            state_reg   <= S_PUT;
                        end
                    end
                    else
                        rd_pend_reg <= 1'b1;
                end
                S_FIND:
                begin
                    if (mode_reg != spq_pkg::MODE_READ && idx_reg == occ_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_HEAD;
                    end
                    else
                        state_reg <= S_FIND_WAIT;
                end
                S_FIND_WAIT:
                begin
                    if (mode_reg == spq_pkg::MODE_READ || rdata_reg.node == node_reg)
                    begin
                        if (!found_reg)
                        begin
                            found_reg <= 1'b1;
                            ent_reg   <= (mode_reg == spq_pkg::MODE_SETPAR) ? rd_par_upd
                                                                            : rdata_reg;
                        end
                    end
                    if (mode_reg == spq_pkg::MODE_SETPAR)
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_FIND;
                    end
                    else if (mode_reg == spq_pkg::MODE_READ
                             || rdata_reg.node == node_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_HEAD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_FIND;
                    end
                end
                S_HEAD:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_HEAD_WAIT;
                end
                S_HEAD_WAIT:
                begin
                    head_reg      <= (occ_reg == '0) ? '0 : rdata_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign entry_node   = spq_pkg::NODE_W'(ent_reg.node);
    assign entry_cost   = spq_pkg::COST_W'(ent_reg.cost);
    assign entry_parent = spq_pkg::NODE_W'(ent_reg.parent);
    assign head_node    = spq_pkg::NODE_W'(head_reg.node);
    assign head_cost    = spq_pkg::COST_W'(head_reg.cost);
    assign head_parent  = spq_pkg::NODE_W'(head_reg.parent);
    assign entry_count  = 7'(occ_reg);

endmodule

/* design/spq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [spq_pkg::STATUS_W-1:0] status,
    input logic                         found,
    input logic [6:0]                   entry_count
);

    // One result at a time: no request taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_count))
        else $error("result dropped while stalled");

    a_full_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != spq_pkg::ST_OK |-> !found)
        else $error("error status with found set");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 7'(spq_pkg::CAPACITY_DEF))
        else $error("count out of range");

    // A taken request keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a request");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .entry_count (entry_count)
);
